>>> rtl/tce_pkg.sv
package tce_pkg;

	// Table geometry and field widths
	localparam int SLOTS          = 16;
	localparam int KEY_BITS       = 32;
	localparam int VALUE_BITS     = 32;
	localparam int AGE_BITS       = 32;
	localparam int TTL_BITS       = 32;
	localparam int LIMIT_BITS     = 5;
	localparam int CMD_BITS       = 3;
	localparam int COUNT_OUT_BITS = 5;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 32;

	// Slot index and internal count widths (count holds SLOTS plus one held-aside entry)
	localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_BITS = ($clog2(SLOTS + 2) > LIMIT_BITS) ? $clog2(SLOTS + 2) : LIMIT_BITS;

	// Command codes
	localparam logic [CMD_BITS-1:0] CMD_TICK       = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_LOOKUP     = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_PUT        = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_INVALIDATE = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR      = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_TTL   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 2'd1;

	// Register reset values and age ceiling
	localparam logic [TTL_BITS-1:0]   TTL_RESET   = 32'd1000;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
	localparam logic [AGE_BITS-1:0]   AGE_MAX     = '1;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic tick;
		logic lookup;
		logic put_write;
		logic invalidate;
		logic clear_all;
		logic fill;
		logic scan_init;
		logic scan_step;
		logic evict;
		logic load_out;
	} tce_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic over;
		logic scan_last;
		logic pending;
	} tce_stat_t;

	// Lowest set bit of a slot vector
	function automatic logic [IDX_BITS-1:0] lowest_set(input logic [SLOTS-1:0] vec);
		logic [IDX_BITS-1:0] idx;
		idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_BITS'(i);
			end
		end
		return idx;
	endfunction

	// Number of set bits in a slot vector
	function automatic logic [CNT_BITS-1:0] pop_count(input logic [SLOTS-1:0] vec);
		logic [CNT_BITS-1:0] n;
		n = '0;
		for (int i = 0; i < SLOTS; i++) begin
			n = n + CNT_BITS'(vec[i]);
		end
		return n;
	endfunction

endpackage

>>> rtl/tce_ctrl.sv
module tce_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tce_pkg::CMD_BITS-1:0] cmd,
	output logic                         out_valid,
	input  logic                         out_stall,
	input  tce_pkg::tce_stat_t           stat,
	output tce_pkg::tce_cmd_t            ctl
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_FILL  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_EVICT = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                       state_q, state_d;
	logic [tce_pkg::CMD_BITS-1:0] cmd_q;
	logic                         out_valid_q;
	logic                         accept;
	logic                         out_free;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Next state and command decode
	always_comb begin
		ctl         = '0;
		state_d     = state_q;
		ctl.capture = accept;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec       = 1'b1;
				ctl.tick       = (cmd_q == tce_pkg::CMD_TICK);
				ctl.lookup     = (cmd_q == tce_pkg::CMD_LOOKUP);
				ctl.put_write  = (cmd_q == tce_pkg::CMD_PUT);
				ctl.invalidate = (cmd_q == tce_pkg::CMD_INVALIDATE);
				ctl.clear_all  = (cmd_q == tce_pkg::CMD_CLEAR);
				state_d        = (cmd_q == tce_pkg::CMD_PUT) ? S_FILL : S_DONE;
			end
			S_FILL: begin
				ctl.fill = 1'b1;
				if (stat.over) begin
					ctl.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				ctl.evict = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, latched command, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= tce_pkg::CMD_TICK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cmd_q <= cmd;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/tce_dpath.sv
module tce_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tce_pkg::tce_cmd_t                  ctl,
	output tce_pkg::tce_stat_t                 stat,
	input  logic [tce_pkg::KEY_BITS-1:0]       key,
	input  logic [tce_pkg::VALUE_BITS-1:0]     value,
	input  logic                               cfg_we,
	input  logic [tce_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tce_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                               hit,
	output logic [tce_pkg::VALUE_BITS-1:0]     value_out,
	output logic [tce_pkg::COUNT_OUT_BITS-1:0] entry_count
);

	// Slot storage
	logic [tce_pkg::SLOTS-1:0]      valid_q;
	logic [tce_pkg::KEY_BITS-1:0]   slot_key_q   [tce_pkg::SLOTS];
	logic [tce_pkg::VALUE_BITS-1:0] slot_value_q [tce_pkg::SLOTS];
	logic [tce_pkg::AGE_BITS-1:0]   slot_age_q   [tce_pkg::SLOTS];

	// Request, registers, put bookkeeping
	logic [tce_pkg::KEY_BITS-1:0]   key_in_q;
	logic [tce_pkg::VALUE_BITS-1:0] val_in_q;
	logic [tce_pkg::TTL_BITS-1:0]   ttl_q;
	logic [tce_pkg::LIMIT_BITS-1:0] limit_q;
	logic                           pending_q;
	logic [tce_pkg::IDX_BITS-1:0]   scan_idx_q;
	logic                           old_found_q;
	logic [tce_pkg::IDX_BITS-1:0]   old_idx_q;
	logic [tce_pkg::AGE_BITS-1:0]   old_age_q;

	// Result staging and output register
	logic                                res_hit_q;
	logic [tce_pkg::VALUE_BITS-1:0]      res_val_q;
	logic                                out_hit_q;
	logic [tce_pkg::VALUE_BITS-1:0]      out_val_q;
	logic [tce_pkg::COUNT_OUT_BITS-1:0]  out_cnt_q;

	logic [tce_pkg::SLOTS-1:0]    match_vec;
	logic [tce_pkg::SLOTS-1:0]    expired_vec;
	logic                         match_found, free_found, wr_found;
	logic [tce_pkg::IDX_BITS-1:0] match_idx, free_idx, wr_idx;
	logic                         hit_now;
	logic [tce_pkg::CNT_BITS-1:0] cur_count, total, eff_limit, lim_ext;
	logic [tce_pkg::AGE_BITS-1:0] scan_age;
	logic                         scan_take;
	logic                         slot_we;
	logic [tce_pkg::IDX_BITS-1:0] slot_widx;

	// Key compare and expiry check on every slot
	always_comb begin
		for (int i = 0; i < tce_pkg::SLOTS; i++) begin
			match_vec[i]   = valid_q[i] && (slot_key_q[i] == key_in_q);
			expired_vec[i] = valid_q[i] && (slot_age_q[i] > ttl_q);
		end
	end

	assign match_found = |match_vec;
	assign free_found  = ~&valid_q;
	assign match_idx   = tce_pkg::lowest_set(match_vec);
	assign free_idx    = tce_pkg::lowest_set(~valid_q);
	assign wr_found    = match_found || free_found;
	assign wr_idx      = match_found ? match_idx : free_idx;
	assign hit_now     = match_found && (slot_age_q[match_idx] <= ttl_q);

	// Entry count against the effective limit
	assign cur_count = tce_pkg::pop_count(valid_q);
	assign total     = cur_count + tce_pkg::CNT_BITS'(pending_q);
	assign lim_ext   = tce_pkg::CNT_BITS'(limit_q);
	assign eff_limit = (lim_ext > tce_pkg::CNT_BITS'(tce_pkg::SLOTS)) ?
		tce_pkg::CNT_BITS'(tce_pkg::SLOTS) : lim_ext;

	// Oldest-entry scan, one slot per cycle
	assign scan_age  = slot_age_q[scan_idx_q];
	assign scan_take = valid_q[scan_idx_q] && (!old_found_q || (scan_age > old_age_q));

	assign stat.over      = (total > eff_limit);
	assign stat.scan_last = (scan_idx_q == tce_pkg::IDX_BITS'(tce_pkg::SLOTS - 1));
	assign stat.pending   = pending_q;

	// Single slot write port: put, fill of a freed slot, replace of the evicted one
	always_comb begin
		slot_we   = 1'b0;
		slot_widx = wr_idx;
		priority if (ctl.put_write && wr_found) begin
			slot_we   = 1'b1;
			slot_widx = wr_idx;
		end else if (ctl.fill && pending_q && free_found) begin
			slot_we   = 1'b1;
			slot_widx = free_idx;
		end else if (ctl.evict && old_found_q && pending_q) begin
			slot_we   = 1'b1;
			slot_widx = old_idx_q;
		end else begin
			slot_we   = 1'b0;
			slot_widx = wr_idx;
		end
	end

	// Valid bits, pending flag, registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			pending_q <= 1'b0;
			ttl_q     <= tce_pkg::TTL_RESET;
			limit_q   <= tce_pkg::LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tce_pkg::CFG_TTL) begin
					ttl_q <= cfg_data[tce_pkg::TTL_BITS-1:0];
				end else if (cfg_index == tce_pkg::CFG_LIMIT) begin
					limit_q <= cfg_data[tce_pkg::LIMIT_BITS-1:0];
				end
			end
			if (ctl.clear_all) begin
				valid_q <= '0;
			end
			if (ctl.invalidate && match_found) begin
				valid_q[match_idx] <= 1'b0;
			end
			if (ctl.put_write) begin
				// expire first; the slot just written has age zero and stays
				valid_q   <= valid_q & ~expired_vec;
				pending_q <= !wr_found;
				if (wr_found) begin
					valid_q[wr_idx] <= 1'b1;
				end
			end
			if (ctl.fill && pending_q && free_found) begin
				valid_q[free_idx] <= 1'b1;
				pending_q         <= 1'b0;
			end
			if (ctl.evict) begin
				// held-aside entry takes the evicted slot, or is dropped itself
				if (old_found_q) begin
					valid_q[old_idx_q] <= pending_q;
				end
				pending_q <= 1'b0;
			end
		end
	end

	// Slot payload: aging and writes
	always_ff @(posedge clk) begin
		if (ctl.tick) begin
			for (int i = 0; i < tce_pkg::SLOTS; i++) begin
				if (valid_q[i] && (slot_age_q[i] != tce_pkg::AGE_MAX)) begin
					slot_age_q[i] <= slot_age_q[i] + 1'b1;
				end
			end
		end
		if (slot_we) begin
			slot_key_q[slot_widx]   <= key_in_q;
			slot_value_q[slot_widx] <= val_in_q;
			slot_age_q[slot_widx]   <= '0;
		end
	end

	// Request capture, scan state, results
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			key_in_q <= key;
			val_in_q <= value;
		end
		if (ctl.scan_init) begin
			scan_idx_q  <= '0;
			old_found_q <= 1'b0;
		end else if (ctl.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_take) begin
				old_found_q <= 1'b1;
				old_idx_q   <= scan_idx_q;
				old_age_q   <= scan_age;
			end
		end
		if (ctl.exec) begin
			res_hit_q <= ctl.lookup && hit_now;
			res_val_q <= (ctl.lookup && hit_now) ? slot_value_q[match_idx] : '0;
		end
		if (ctl.load_out) begin
			out_hit_q <= res_hit_q;
			out_val_q <= res_val_q;
			out_cnt_q <= cur_count[tce_pkg::COUNT_OUT_BITS-1:0];
		end
	end

	assign hit         = out_hit_q;
	assign value_out   = out_val_q;
	assign entry_count = out_cnt_q;

endmodule

>>> rtl/ttl_cache_oldest_eviction_unit.sv
// Each request steps through EXEC and DONE for tick, lookup, invalidate, clear and unknown
// commands, through EXEC, FILL and DONE for a put without eviction, and through EXEC, FILL,
// SCAN over all slots, EVICT and DONE for a put that evicts. A new request is stalled until
// the result is loaded into the output register; the oldest-entry search reads one slot age per cycle.
// Reset (arst_n, asynchronous): table empty, ttl_ticks 1000, capacity_limit 16, no
// clearing pass; the first request is taken right after reset.
module ttl_cache_oldest_eviction_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tce_pkg::CMD_BITS-1:0]       cmd,
	input  logic [tce_pkg::KEY_BITS-1:0]       key,
	input  logic [tce_pkg::VALUE_BITS-1:0]     value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [tce_pkg::VALUE_BITS-1:0]     value_out,
	output logic [tce_pkg::COUNT_OUT_BITS-1:0] entry_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tce_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tce_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	tce_pkg::tce_cmd_t  ctl;
	tce_pkg::tce_stat_t stat;

	// registers are always writable
	assign cfg_ready = 1'b1;

	tce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	tce_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.key         (key),
		.value       (value),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.hit         (hit),
		.value_out   (value_out),
		.entry_count (entry_count)
	);

	// a held-aside put entry is always resolved before the next request
	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !stat.pending)
		else $error("pending entry left over while idle");

	// reported count never exceeds the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= tce_pkg::COUNT_OUT_BITS'(tce_pkg::SLOTS)))
		else $error("entry count above table size");

	// a miss always reports a zero value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (value_out == '0))
		else $error("nonzero value on a miss");

	// one request at a time: accept is followed by stall
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while busy");

	// eviction only runs after a put that went over the limit
	a_evict_after_over: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_init |-> (ctl.fill && stat.over))
		else $error("scan started without overflow");

endmodule
